@@ design/idq_pkg.sv @@
// Package: sizes, payload types, operation and status codes of the indexed deque engine.
`default_nettype none

package idq_pkg;

  localparam int DEPTH     = 32;
  localparam int DATA_W    = 32;
  localparam int OPC_W     = 2;
  localparam int POS_W     = 6;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 6;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [OPC_W-1:0]         opcode_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]         position_t;
  typedef logic [ST_W-1:0]          status_t;
  typedef logic [CNT_OUT_W-1:0]     count_t;
  typedef logic [CNT_W-1:0]         fill_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CMP_W-1:0]         cmp_t;

  localparam opcode_t OP_PUSH   = 2'd0;
  localparam opcode_t OP_POP    = 2'd1;
  localparam opcode_t OP_INSERT = 2'd2;
  localparam opcode_t OP_REMOVE = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  localparam data_t NEG_ONE = '1;

endpackage

`default_nettype wire

@@ design/idq_if.sv @@
// Interfaces: request channel and result channel, valid/ready handshake.
`default_nettype none

interface idq_req_if;
  import idq_pkg::*;

  logic      valid;
  logic      ready;
  opcode_t   opcode;
  data_t     data_value;
  position_t position;

  modport source (output valid, output opcode, output data_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input data_value, input position,
                  output ready);
endinterface

interface idq_rsp_if;
  import idq_pkg::*;

  logic    valid;
  logic    ready;
  data_t   popped_value;
  status_t status;
  count_t  entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ design/indexed_deque_engine_top.sv @@
// The result is registered and goes valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled; every slot shifts or holds in parallel
//   from the decoded position, so no operation iterates over the sequence.
// A result waiting on a stalled output still lets the next request in when it is taken.
// Reset (rst_n low, synchronous): count and result valid cleared; slot contents
//   are left as they are and only read once written.
`default_nettype none

module indexed_deque_engine_top (
  input  logic      clk,
  input  logic      rst_n,
  idq_req_if.sink   in_ch,
  idq_rsp_if.source out_ch
);
  import idq_pkg::*;

  // Sequence storage: slot 0 is the front
  data_t   slots_r [DEPTH];
  fill_t   fill_r;
  fill_t   fill_nxt;

  // Result register
  logic    out_valid_r;
  data_t   popped_r;
  data_t   popped_nxt;
  status_t status_r;
  status_t status_nxt;
  count_t  count_r;

  logic    accept;
  logic    full;
  logic    empty;
  logic    do_ins;
  logic    do_rem;
  cmp_t    pos_c;
  cmp_t    fill_c;
  cmp_t    edit_pos;
  idx_t    last_idx;

  // Take a new request whenever the result register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pos_c    = CMP_W'(in_ch.position);
  assign fill_c   = CMP_W'(fill_r);
  assign last_idx = IDX_W'(fill_r - CNT_W'(1));

  // Decode: status, popped value, next count and which shift to apply.
  // Full is checked before the position for insert.
  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    edit_pos   = '0;
    status_nxt = ST_OK;
    popped_nxt = '0;
    fill_nxt   = fill_r;
    case (in_ch.opcode)
      OP_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins   = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
          popped_nxt = NEG_ONE;
        end else begin
          popped_nxt = slots_r[last_idx];
          fill_nxt   = fill_r - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        edit_pos = pos_c;
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_c > fill_c) begin
          status_nxt = ST_RANGE;
        end else begin
          do_ins   = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        edit_pos = pos_c;
        if (pos_c >= fill_c) begin
          status_nxt = ST_RANGE;
        end else begin
          do_rem   = 1'b1;
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  // Per-slot shift: insert moves slots at and above the position back by one
  // and writes the new value at the position; remove pulls later slots forward.
  // Slots at or past the count may take stale data; they are never read.
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    localparam int   PREV = (g == 0) ? 0 : g - 1;
    localparam int   NEXT = (g == DEPTH - 1) ? g : g + 1;
    localparam cmp_t IDX  = CMP_W'(g);

    always_ff @(posedge clk) begin
      if (accept && do_ins && (IDX >= edit_pos)) begin
        if (IDX == edit_pos) begin
          slots_r[g] <= in_ch.data_value;
        end else begin
          slots_r[g] <= slots_r[PREV];
        end
      end else if (accept && do_rem && (IDX >= edit_pos)) begin
        slots_r[g] <= slots_r[NEXT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      count_r  <= CNT_OUT_W'(fill_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = count_r;

endmodule

`default_nettype wire

@@ design/idq_checker.sv @@
// Checker: port-level assertions for the indexed deque engine, bound to the top level.
`default_nettype none

module idq_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input idq_pkg::data_t   popped_value,
  input idq_pkg::status_t status,
  input idq_pkg::count_t  entry_count
);
  import idq_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(status)
                                && $stable(entry_count))
    else $error("result changed while stalled");

  // Each accepted request yields a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(entry_count) <= DEPTH)
    else $error("entry count beyond depth");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> popped_value == NEG_ONE && entry_count == '0)
    else $error("empty pop result malformed");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_RANGE || status == ST_FULL) |-> popped_value == '0)
    else $error("refused request returned a value");

endmodule

bind indexed_deque_engine_top idq_checker u_idq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .popped_value (out_ch.popped_value),
  .status       (out_ch.status),
  .entry_count  (out_ch.entry_count)
);

`default_nettype wire
